@@ hdl/delta_varlen_bit_packer_assert.svh @@
// assertion macros for the delta varlen bit packer checker
// no dependencies; included by the checker file

`ifndef DELTA_VARLEN_BIT_PACKER_ASSERT_SVH
`define DELTA_VARLEN_BIT_PACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DVBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DVBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dvbp_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and a function of the delta varlen bit packer
// no dependencies

package dvbp_pkg;

    localparam int WORD_W  = 32;
    localparam int MCB_W   = 5;
    localparam int LEN_W   = 6;
    localparam int BITS_W  = 63;
    localparam int NBITS_W = 6;
    localparam int FILL_W  = 5;
    localparam int PART_W  = 31;
    localparam int TOTAL_W = 7;
    localparam int CNT_W   = 2;
    localparam int COMB_W  = 95;

    localparam logic [MCB_W-1:0]  MCB_RESET  = 5'd7;
    localparam logic [WORD_W-1:0] PREV_RESET = {WORD_W{1'b1}};

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // packed code of one value
    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
    } t_code;

    // up to two words produced by one item
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] word0;
        logic              last0;
        logic [WORD_W-1:0] word1;
        logic              last1;
    } t_result;

    // bit length of a nonzero word
    function automatic logic [LEN_W-1:0] bit_len(input logic [WORD_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/delta_varlen_bit_packer.sv @@
`timescale 1ns / 1ps
// flow: a beat waits in the input register until its words fit in the result register
// throughput: one item per cycle while the output is not stalled and items yield
//   at most one word each; the output port moves one beat a cycle unless stalled
// reset: synchronous, active low; clears the stream state, sets min_code_bits to 7
//   and drops any pending beats
// depends on dvbp_pkg, dvbp_coder, dvbp_packer, dvbp_out_buf

module delta_varlen_bit_packer import dvbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [WORD_W-1:0] i_value,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_packed_word,
    output logic              o_last,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MCB_W-1:0]  i_cfg_data
);

    // input register
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [WORD_W-1:0] r_value;

    // minimum code width register
    logic [MCB_W-1:0]  r_mcb;

    logic              in_accept;
    logic              step;
    logic              buf_space;
    logic [WORD_W-1:0] prev_value;
    t_code             code;
    t_result           result;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // the held item moves on when its words fit in the result register;
    // an item that yields no word moves on regardless
    assign step       = r_in_valid && ((result.cnt == '0) || buf_space);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcb <= MCB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mcb <= i_cfg_data;
        end
    end

    // gap, odd code and its prefix form
    dvbp_coder u_coder (
        .i_value         (r_value),
        .i_prev_value    (prev_value),
        .i_min_code_bits (r_mcb),
        .o_code          (code)
    );

    // bit accumulator and word split
    dvbp_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cmd        (r_cmd),
        .i_value      (r_value),
        .i_code       (code),
        .o_prev_value (prev_value),
        .o_result     (result)
    );

    // result register, one beat out per cycle while the output is not stalled
    dvbp_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (step),
        .i_result      (result),
        .i_out_stall   (i_out_stall),
        .o_space       (buf_space),
        .o_out_valid   (o_out_valid),
        .o_packed_word (o_packed_word),
        .o_last        (o_last)
    );

endmodule

@@ hdl/dvbp_coder.sv @@
`timescale 1ns / 1ps
// gap to odd code, length encode and prefix form of one value
// depends on dvbp_pkg

module dvbp_coder import dvbp_pkg::*; (
    input  logic [WORD_W-1:0] i_value,
    input  logic [WORD_W-1:0] i_prev_value,
    input  logic [MCB_W-1:0]  i_min_code_bits,
    output t_code             o_code
);

    logic [WORD_W-1:0]  gap;
    logic [WORD_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   mcb_ext;
    logic [LEN_W-1:0]   prefix;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  payload;
    logic               is_long;

    always_comb begin
        gap     = i_value - i_prev_value;
        code    = {gap[WORD_W-2:0], 1'b0} - WORD_W'(1);
        len     = bit_len(code);
        len_m1  = len - LEN_W'(1);
        mcb_ext = {1'b0, i_min_code_bits};
        is_long = len > mcb_ext;
        prefix  = len - mcb_ext;
        // top bit of the code is implied by the zero-run prefix
        mask    = ~({WORD_W{1'b1}} << len_m1[FILL_W-1:0]);
        payload = code & mask;
        if (is_long) begin
            o_code.bits  = {{(BITS_W-WORD_W){1'b0}}, payload} << prefix;
            o_code.nbits = prefix + len_m1;
        end else begin
            o_code.bits  = {{(BITS_W-WORD_W){1'b0}}, code};
            o_code.nbits = mcb_ext;
        end
    end

endmodule

@@ hdl/dvbp_packer.sv @@
`timescale 1ns / 1ps
// stream state and word assembly of the delta varlen bit packer
// depends on dvbp_pkg

module dvbp_packer import dvbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_cmd              i_cmd,
    input  logic [WORD_W-1:0] i_value,
    input  t_code             i_code,
    output logic [WORD_W-1:0] o_prev_value,
    output t_result           o_result
);

    logic [WORD_W-1:0]  r_prev;
    logic [PART_W-1:0]  r_partial;
    logic [FILL_W-1:0]  r_fill;

    logic [WORD_W-1:0]  n_prev;
    logic [PART_W-1:0]  n_partial;
    logic [FILL_W-1:0]  n_fill;

    logic [COMB_W-1:0]  merged;
    logic [TOTAL_W-1:0] total;

    assign o_prev_value = r_prev;

    always_comb begin
        merged = ({{(COMB_W-BITS_W){1'b0}}, i_code.bits} << r_fill)
               | {{(COMB_W-PART_W){1'b0}}, r_partial};
        total  = {2'b00, r_fill} + {1'b0, i_code.nbits};

        o_result  = '0;
        n_prev    = r_prev;
        n_partial = r_partial;
        n_fill    = r_fill;

        unique case (i_cmd)
            CMD_FINISH: begin
                // flush the partial word if any, then the terminating zero word
                if (r_fill != '0) begin
                    o_result.cnt   = 2'd2;
                    o_result.word0 = {1'b0, r_partial};
                    o_result.last1 = 1'b1;
                end else begin
                    o_result.cnt   = 2'd1;
                    o_result.last0 = 1'b1;
                end
                n_prev    = PREV_RESET;
                n_partial = '0;
                n_fill    = '0;
            end
            CMD_ADD: begin
                o_result.word0 = merged[WORD_W-1:0];
                o_result.word1 = merged[2*WORD_W-1:WORD_W];
                n_prev         = i_value;
                n_fill         = total[FILL_W-1:0];
                if (total[TOTAL_W-1]) begin
                    o_result.cnt = 2'd2;
                    n_partial    = merged[2*WORD_W+PART_W-1:2*WORD_W];
                end else if (total[TOTAL_W-2]) begin
                    o_result.cnt = 2'd1;
                    n_partial    = merged[WORD_W+PART_W-1:WORD_W];
                end else begin
                    o_result.cnt = 2'd0;
                    n_partial    = merged[PART_W-1:0];
                end
            end
            default: begin
                o_result.cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= PREV_RESET;
            r_partial <= '0;
            r_fill    <= '0;
        end else if (i_step) begin
            r_prev    <= n_prev;
            r_partial <= n_partial;
            r_fill    <= n_fill;
        end
    end

endmodule

@@ hdl/dvbp_out_buf.sv @@
`timescale 1ns / 1ps
// two-entry result register that drains one beat per cycle while the output is not stalled
// depends on dvbp_pkg

module dvbp_out_buf import dvbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    input  logic              i_out_stall,
    output logic              o_space,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_packed_word,
    output logic              o_last
);

    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_word0;
    logic [WORD_W-1:0] r_word1;
    logic              r_last0;
    logic              r_last1;
    logic              pop;
    logic              load;

    assign o_out_valid   = r_cnt != '0;
    assign o_packed_word = r_word0;
    assign o_last        = r_last0;
    assign pop           = o_out_valid && !i_out_stall;
    assign o_space       = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign load          = i_load && (i_result.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_result.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word0 <= i_result.word0;
            r_last0 <= i_result.last0;
            r_word1 <= i_result.word1;
            r_last1 <= i_result.last1;
        end else if (pop) begin
            r_word0 <= r_word1;
            r_last0 <= r_last1;
        end
    end

endmodule

@@ hdl/dvbp_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the delta varlen bit packer, bound to the top level
// depends on delta_varlen_bit_packer_assert.svh

`include "delta_varlen_bit_packer_assert.svh"

module dvbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_packed_word,
    input logic        o_last
);

    // a stalled beat holds
    `DVBP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall), (o_out_valid && $stable(o_packed_word) && $stable(o_last)), "output beat changed under stall")

    // the terminating word is all zero
    `DVBP_ASSERT_IMP(a_last_zero, i_clk, i_rst_n, (o_out_valid && o_last), (o_packed_word == 32'd0), "last beat carries nonzero word")

    // with nothing waiting at the output the input never stalls
    `DVBP_ASSERT_IMP(a_no_idle_stall, i_clk, i_rst_n, (!o_out_valid), (!o_in_stall), "input stalled while output empty")

    // no beat right after reset
    `DVBP_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, ($past(!i_rst_n)), (!o_out_valid), "output valid right after reset")

endmodule

bind delta_varlen_bit_packer dvbp_checker u_dvbp_checker (.*);
